@@ src/vdib_pkg.sv @@
// shared types, constants and helpers for the vertex dedup index builder
package vdib_pkg;

  localparam int TABLE_DEPTH_DEF = 4096;
  localparam int KEY_W = 256;
  localparam int EPOCH_W = 8;
  localparam int INDEX_OUT_W = 12;
  localparam int PADDR_W = 3;

  localparam logic [0:0] REG_USE_UV = 1'b0;
  localparam logic [0:0] REG_USE_NORMAL = 1'b1;

  localparam logic [63:0] HASH_C1 = 64'h9E3779B97F4A7C15;
  localparam logic [63:0] HASH_C2 = 64'hC2B2AE3D27D4EB4F;
  localparam logic [63:0] HASH_C3 = 64'h165667B19E3779F9;
  localparam logic [63:0] HASH_C4 = 64'hBF58476D1CE4E5B9;

  typedef struct packed {
    logic        mesh_start;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic [31:0] pos_z;
    logic [31:0] tex_u;
    logic [31:0] tex_v;
    logic [31:0] norm_x;
    logic [31:0] norm_y;
    logic [31:0] norm_z;
  } vtx_t;

  typedef struct packed {
    logic [INDEX_OUT_W-1:0] vert_idx;
    logic                   is_new;
    logic                   table_full;
  } res_t;

  typedef struct packed {
    logic [63:0] d;
    logic [63:0] c;
    logic [63:0] b;
    logic [63:0] a;
  } key_t;

  // one 32x32 partial product of a 64-bit product taken mod 2^64
  function automatic logic [63:0] part_mul(input logic [63:0] x, input logic [63:0] cst,
                                           input logic [1:0] j);
    logic [63:0] lo;
    logic [63:0] p;
    begin
      lo = 64'd0;
      case (j)
        2'd0: begin
          p = 64'(x[31:0]) * 64'(cst[31:0]);
        end
        2'd1: begin
          lo = 64'(x[31:0]) * 64'(cst[63:32]);
          p = {lo[31:0], 32'd0};
        end
        2'd2: begin
          lo = 64'(x[63:32]) * 64'(cst[31:0]);
          p = {lo[31:0], 32'd0};
        end
        default: begin
          p = 64'd0;
        end
      endcase
      return p;
    end
  endfunction

endpackage

@@ src/vdib_ram.sv @@
// generic single-port ram with registered read
module vdib_ram
  #(parameter int WIDTH = 8,
    parameter int DEPTH = 16)
  (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
  );

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

@@ src/vdib_hash.sv @@
// front end: takes a vertex beat, builds the masked key and hashes it to a start slot
module vdib_hash
  import vdib_pkg::*;
  #(parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(TABLE_DEPTH))
  (
  input  logic             clk,
  input  logic             rst,
  input  logic             vtx_valid,
  output logic             vtx_ready,
  input  vtx_t             vtx,
  input  logic             use_uv,
  input  logic             use_normal,
  input  logic             hold,
  output logic             out_valid,
  input  logic             out_ready,
  output key_t             out_key,
  output logic             out_mesh,
  output logic [IDX_W-1:0] out_slot
  );

  typedef enum logic [3:0] {
    H_IDLE = 4'b0001,
    H_MULA = 4'b0010,
    H_MULB = 4'b0100,
    H_DONE = 4'b1000
  } hstate_t;

  hstate_t          state;
  logic [1:0]       step;
  key_t             key;
  logic             mesh;
  logic [63:0]      acc_b, acc_c, acc_d, acc_h;
  logic [63:0]      pp_b, pp_c, pp_d, pp_h;
  logic [IDX_W-1:0] slot;

  key_t             key_in;
  logic [63:0]      hx0, hx, hsum, h2;
  logic [IDX_W:0]   slot_raw;
  logic [IDX_W-1:0] slot_in;

  always_comb begin
    key_in.a = {vtx.pos_y, vtx.pos_x};
    key_in.b = {(use_uv ? vtx.tex_u : 32'd0), vtx.pos_z};
    key_in.c = {(use_normal ? vtx.norm_x : 32'd0), (use_uv ? vtx.tex_v : 32'd0)};
    key_in.d = {(use_normal ? vtx.norm_z : 32'd0), (use_normal ? vtx.norm_y : 32'd0)};
    hx0 = key.a ^ acc_b ^ acc_c ^ acc_d;
    hx = hx0 ^ (hx0 >> 29);
    hsum = acc_h + pp_h;
    h2 = hsum ^ (hsum >> 32);
    // the start slot only steers the probe, so one fold into range serves any depth
    slot_raw = {1'b0, h2[IDX_W-1:0]};
    if (slot_raw >= (IDX_W+1)'(TABLE_DEPTH)) begin
      slot_in = IDX_W'(slot_raw - (IDX_W+1)'(TABLE_DEPTH));
    end else begin
      slot_in = slot_raw[IDX_W-1:0];
    end
  end

  assign vtx_ready = (state == H_IDLE) && !hold;
  assign out_valid = (state == H_DONE);
  assign out_key = key;
  assign out_mesh = mesh;
  assign out_slot = slot;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= H_IDLE;
      step <= 2'd0;
    end else begin
      case (state)
        H_IDLE: begin
          if (vtx_valid && vtx_ready) begin
            key <= key_in;
            mesh <= vtx.mesh_start;
            step <= 2'd0;
            acc_b <= 64'd0;
            acc_c <= 64'd0;
            acc_d <= 64'd0;
            state <= H_MULA;
          end
        end
        H_MULA: begin
          pp_b <= part_mul(key.b, HASH_C1, step);
          pp_c <= part_mul(key.c, HASH_C2, step);
          pp_d <= part_mul(key.d, HASH_C3, step);
          if (step != 2'd0) begin
            acc_b <= acc_b + pp_b;
            acc_c <= acc_c + pp_c;
            acc_d <= acc_d + pp_d;
          end
          step <= step + 2'd1;
          if (step == 2'd3) begin
            acc_h <= 64'd0;
            state <= H_MULB;
          end
        end
        H_MULB: begin
          pp_h <= part_mul(hx, HASH_C4, step);
          if (step != 2'd0) begin
            acc_h <= hsum;
          end
          step <= step + 2'd1;
          if (step == 2'd3) begin
            slot <= slot_in;
            state <= H_DONE;
          end
        end
        H_DONE: begin
          if (out_ready) begin
            state <= H_IDLE;
          end
        end
        default: begin
          state <= H_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/vdib_queue.sv @@
// short fifo between the hash front end and the probe back end
module vdib_queue
  #(parameter int WIDTH = 8)
  (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr_valid,
  output logic             wr_ready,
  input  logic [WIDTH-1:0] wr_data,
  output logic             rd_valid,
  input  logic             rd_ready,
  output logic [WIDTH-1:0] rd_data
  );

  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr, rd_ptr;
  logic [1:0]       count;
  logic             push, pop;

  assign wr_ready = (count != 2'd2);
  assign rd_valid = (count != 2'd0);
  assign rd_data = slots[rd_ptr];
  assign push = wr_valid && wr_ready;
  assign pop = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push, pop})
        2'b10: count <= count + 2'd1;
        2'b01: count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

@@ src/vdib_probe.sv @@
// back end: linear probe of the slot table, insert on a free slot, result register
module vdib_probe
  import vdib_pkg::*;
  #(parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    parameter int IDX_W = $clog2(TABLE_DEPTH))
  (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  key_t             q_key,
  input  logic             q_mesh,
  input  logic [IDX_W-1:0] q_slot,
  output logic             res_valid,
  input  logic             res_ready,
  output res_t             res,
  output logic             sweeping
  );

  localparam int W = EPOCH_W + IDX_W + KEY_W;
  localparam logic [IDX_W-1:0] LAST = IDX_W'(TABLE_DEPTH - 1);

  typedef enum logic [4:0] {
    P_SWEEP = 5'b00001,
    P_IDLE  = 5'b00010,
    P_READ  = 5'b00100,
    P_CHECK = 5'b01000,
    P_OUT   = 5'b10000
  } pstate_t;

  pstate_t            state;
  logic [EPOCH_W-1:0] epoch;
  logic [IDX_W:0]     next_index;
  logic [IDX_W-1:0]   pos;
  logic [IDX_W:0]     cnt;
  logic [IDX_W-1:0]   sweep_addr;
  logic               pend;
  key_t               key;
  res_t               res_r;

  logic               ram_we;
  logic [IDX_W-1:0]   ram_addr;
  logic [W-1:0]       ram_wdata, ram_rdata;
  logic [EPOCH_W-1:0] rd_tag;
  logic [IDX_W-1:0]   rd_idx;
  logic [KEY_W-1:0]   rd_key;
  logic               slot_free;

  assign rd_tag = ram_rdata[W-1 -: EPOCH_W];
  assign rd_idx = ram_rdata[KEY_W +: IDX_W];
  assign rd_key = ram_rdata[KEY_W-1:0];
  assign slot_free = (rd_tag != epoch);

  always_comb begin
    ram_we = 1'b0;
    ram_addr = pos;
    ram_wdata = {epoch, next_index[IDX_W-1:0], key};
    if (state == P_SWEEP) begin
      ram_we = 1'b1;
      ram_addr = sweep_addr;
      ram_wdata = '0;
    end else if ((state == P_CHECK) && slot_free) begin
      ram_we = 1'b1;
    end
  end

  vdib_ram #(.WIDTH(W), .DEPTH(TABLE_DEPTH)) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  assign q_ready = (state == P_IDLE);
  assign res_valid = (state == P_OUT);
  assign res = res_r;
  assign sweeping = (state == P_SWEEP) && !pend;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= P_SWEEP;
      sweep_addr <= '0;
      pend <= 1'b0;
      epoch <= '0;
      next_index <= '0;
    end else begin
      case (state)
        P_SWEEP: begin
          sweep_addr <= sweep_addr + IDX_W'(1);
          if (sweep_addr == LAST) begin
            epoch <= EPOCH_W'(1);
            pend <= 1'b0;
            state <= pend ? P_READ : P_IDLE;
          end
        end
        P_IDLE: begin
          if (q_valid) begin
            key <= q_key;
            pos <= q_slot;
            cnt <= '0;
            state <= P_READ;
            if (q_mesh) begin
              next_index <= '0;
              if (epoch == '1) begin
                sweep_addr <= '0;
                pend <= 1'b1;
                state <= P_SWEEP;
              end else begin
                epoch <= epoch + EPOCH_W'(1);
              end
            end
          end
        end
        P_READ: begin
          state <= P_CHECK;
        end
        P_CHECK: begin
          if (slot_free) begin
            res_r <= '{vert_idx: INDEX_OUT_W'(next_index), is_new: 1'b1,
                       table_full: 1'b0};
            next_index <= next_index + (IDX_W+1)'(1);
            state <= P_OUT;
          end else if (rd_key == key) begin
            res_r <= '{vert_idx: INDEX_OUT_W'(rd_idx), is_new: 1'b0, table_full: 1'b0};
            state <= P_OUT;
          end else if (cnt == (IDX_W+1)'(TABLE_DEPTH - 1)) begin
            res_r <= '{vert_idx: '0, is_new: 1'b0, table_full: 1'b1};
            state <= P_OUT;
          end else begin
            cnt <= cnt + (IDX_W+1)'(1);
            pos <= (pos == LAST) ? '0 : pos + IDX_W'(1);
            state <= P_READ;
          end
        end
        P_OUT: begin
          if (res_ready) begin
            state <= P_IDLE;
          end
        end
        default: begin
          state <= P_IDLE;
        end
      endcase
    end
  end

endmodule

@@ src/vertex_dedup_index_builder.sv @@
// top level of the vertex dedup index builder
//
//   channel | direction | handshake             | beat
//   vtx     | in        | vtx_valid / vtx_ready | vtx_t: mesh flag and 8 float words
//   res     | out       | res_valid / res_ready | res_t: index, new flag, full flag
//   apb     | in        | psel/penable/pwrite   | use_uv at 0x0, use_normal at 0x4
//
// each beat is hashed in H_MULA then H_MULB; no new beat is taken until it is queued
// the probe takes one beat at a time: P_READ and P_CHECK per slot visited, then P_OUT
// a miss on a full table visits every slot before it reports full
// after reset a clearing pass writes every slot before the first vertex is taken
// every 255th mesh start runs the same pass before that vertex is looked up
// a two-beat queue sits between hashing and probing, so either side may stall alone
module vertex_dedup_index_builder
  import vdib_pkg::*;
  #(parameter int TABLE_DEPTH = TABLE_DEPTH_DEF)
  (
  input  logic               clk,
  input  logic               rst,
  input  logic               vtx_valid,
  output logic               vtx_ready,
  input  vtx_t               vtx,
  output logic               res_valid,
  input  logic               res_ready,
  output res_t               res,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
  );

  localparam int IDX_W = $clog2(TABLE_DEPTH);
  localparam int QW = 1 + KEY_W + IDX_W;

  logic             use_uv, use_normal;
  logic             sweeping;
  logic             h_valid, h_ready;
  key_t             h_key;
  logic             h_mesh;
  logic [IDX_W-1:0] h_slot;
  logic             q_valid, q_ready;
  logic [QW-1:0]    q_data;
  key_t             q_key;
  logic             q_mesh;
  logic [IDX_W-1:0] q_slot;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      use_uv <= 1'b0;
      use_normal <= 1'b0;
    end else if (psel && penable && pwrite && pready) begin
      case (paddr[2])
        REG_USE_UV: use_uv <= pwdata[0];
        REG_USE_NORMAL: use_normal <= pwdata[0];
        default: use_uv <= use_uv;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      REG_USE_UV: prdata = {31'd0, use_uv};
      REG_USE_NORMAL: prdata = {31'd0, use_normal};
      default: prdata = 32'd0;
    endcase
  end

  vdib_hash #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_hash (
    .clk        (clk),
    .rst        (rst),
    .vtx_valid  (vtx_valid),
    .vtx_ready  (vtx_ready),
    .vtx        (vtx),
    .use_uv     (use_uv),
    .use_normal (use_normal),
    .hold       (sweeping),
    .out_valid  (h_valid),
    .out_ready  (h_ready),
    .out_key    (h_key),
    .out_mesh   (h_mesh),
    .out_slot   (h_slot)
  );

  vdib_queue #(.WIDTH(QW)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr_valid (h_valid),
    .wr_ready (h_ready),
    .wr_data  ({h_mesh, h_key, h_slot}),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_data  (q_data)
  );

  assign q_mesh = q_data[QW-1];
  assign q_key = q_data[IDX_W +: KEY_W];
  assign q_slot = q_data[IDX_W-1:0];

  vdib_probe #(.TABLE_DEPTH(TABLE_DEPTH), .IDX_W(IDX_W)) u_probe (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_key     (q_key),
    .q_mesh    (q_mesh),
    .q_slot    (q_slot),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res),
    .sweeping  (sweeping)
  );

endmodule

@@ src/vdib_checker.sv @@
// port-level checks for the vertex dedup index builder, bound to the top level
module vdib_checker
  import vdib_pkg::*;
  (
  input logic clk,
  input logic rst,
  input logic res_valid,
  input logic res_ready,
  input res_t res,
  input logic pready
  );

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result beat dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res))
    else $error("result beat changed while stalled");

  a_flags_excl: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> !(res.is_new && res.table_full))
    else $error("new and full flagged together");

  a_full_zero: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.table_full |-> res.vert_idx == '0)
    else $error("full result carries an index");

  a_pready: assert property (@(posedge clk) pready)
    else $error("pready low");

endmodule

bind vertex_dedup_index_builder vdib_checker u_vdib_checker (
  .clk       (clk),
  .rst       (rst),
  .res_valid (res_valid),
  .res_ready (res_ready),
  .res       (res),
  .pready    (pready)
);
